[rtl/nested_cycle_profiler_defines.svh]
// Assertion macros for the nested cycle profiler.
`ifndef NESTED_CYCLE_PROFILER_DEFINES_SVH
`define NESTED_CYCLE_PROFILER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, disabled during reset.
`define NCP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define NCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define NCP_ASSERT_IMP(lbl, ante, cons, msg)

`define NCP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/ncp_pkg.sv]
// Shared types and constants of the nested cycle profiler.
package ncp_pkg;

	localparam int NUM_COUNTERS_DEF = 16;

	localparam int FUNC_W = 2;
	localparam int ID_W   = 8;
	localparam int OV_W   = 16;
	localparam int TIME_W = 64;
	localparam int ST_W   = 3;
	localparam int SID_W  = 4;
	localparam int ACC_W  = 32;

	localparam logic [FUNC_W-1:0] FN_REG   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_UNREG = 2'd1;
	localparam logic [FUNC_W-1:0] FN_START = 2'd2;
	localparam logic [FUNC_W-1:0] FN_STOP  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 3'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
	localparam logic [ST_W-1:0] ST_DUP   = 3'd2;
	localparam logic [ST_W-1:0] ST_UNREG = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;
	localparam logic [ST_W-1:0] ST_BUSY  = 3'd5;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [OV_W-1:0]   overhead;
		logic [ID_W-1:0]   counter_id;
		logic [FUNC_W-1:0] func;
	} item_t;

	typedef struct packed {
		logic [ACC_W-1:0]  stopped_overhead;
		logic [TIME_W-1:0] measured_cycles;
		logic [SID_W-1:0]  stopped_id;
		logic              measured_valid;
		logic [ST_W-1:0]   status;
	} result_t;

endpackage

[rtl/ncp_engine.sv]
// Operation sequencer with the start-cycle, overhead and active-stack memories.
`include "nested_cycle_profiler_defines.svh"

module ncp_engine
	import ncp_pkg::*;
#(
	parameter int NUM_COUNTERS = NUM_COUNTERS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int CW = $clog2(NUM_COUNTERS);
	localparam int DW = $clog2(NUM_COUNTERS + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_POPRD  = 7'b0000100,
		S_CNTRD  = 7'b0001000,
		S_SUB    = 7'b0010000,
		S_WALK   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t                  state_q;
	item_t                   item_q;
	logic [NUM_COUNTERS-1:0] reg_flags_q;
	logic [NUM_COUNTERS-1:0] act_flags_q;
	logic [DW-1:0]           depth_q;
	logic [ST_W-1:0]         status_q;
	logic                    mvalid_q;
	logic [CW-1:0]           pop_id_q;
	logic [TIME_W-1:0]       diff_q;
	logic [TIME_W-1:0]       cycles_q;
	logic [ACC_W-1:0]        acc_q;
	logic [DW-1:0]           walk_n_q;
	logic [DW-1:0]           issue_q;
	logic                    v_s1;
	logic                    v_s2;
	logic [CW-1:0]           c_s2;

	logic [TIME_W-1:0] start_mem [NUM_COUNTERS];
	logic [ACC_W-1:0]  acc_mem   [NUM_COUNTERS];
	logic [CW-1:0]     stack_mem [NUM_COUNTERS];
	logic [TIME_W-1:0] start_rd_q;
	logic [ACC_W-1:0]  acc_rd_q;
	logic [CW-1:0]     stack_rd_q;

	logic [CW-1:0]     cid;
	logic              id_oor;
	logic              ov_nz;
	logic [DW-1:0]     depth_m1;
	logic [CW-1:0]     stack_raddr;
	logic              walk_more;
	logic [ST_W-1:0]   dec_status;
	logic              do_reg;
	logic              do_unreg;
	logic              do_start;
	logic              do_pop;
	logic              start_we;
	logic [TIME_W-1:0] start_wdata;
	logic              acc_we;
	logic [CW-1:0]     acc_waddr;
	logic [ACC_W-1:0]  acc_wdata;
	logic              stack_we;
	logic [ACC_W:0]    sat_sum;
	logic [ID_W-1:0]   pop_id8;

	assign cid       = item_q.counter_id[CW-1:0];
	assign id_oor    = {1'b0, item_q.counter_id} >= (ID_W+1)'(NUM_COUNTERS);
	assign ov_nz     = item_q.overhead != '0;
	assign depth_m1  = depth_q - DW'(1);
	assign walk_more = issue_q < walk_n_q;
	assign stack_raddr = (state_q == S_DECODE) ? depth_m1[CW-1:0] : issue_q[CW-1:0];
	assign sat_sum   = {1'b0, acc_rd_q} + (ACC_W+1)'(item_q.overhead);

	always_comb begin
		dec_status = ST_OK;
		do_reg     = 1'b0;
		do_unreg   = 1'b0;
		do_start   = 1'b0;
		do_pop     = 1'b0;
		case (item_q.func)
			FN_STOP: begin
				if (depth_q == '0) dec_status = ST_EMPTY;
				else do_pop = 1'b1;
			end
			default: begin
				if (id_oor) begin
					dec_status = ST_RANGE;
				end else begin
					case (item_q.func)
						FN_REG: begin
							if (reg_flags_q[cid]) dec_status = ST_DUP;
							else do_reg = 1'b1;
						end
						FN_UNREG: begin
							if (!reg_flags_q[cid]) dec_status = ST_UNREG;
							else do_unreg = 1'b1;
						end
						default: begin
							if (!reg_flags_q[cid]) dec_status = ST_UNREG;
							else if (act_flags_q[cid] || depth_q == DW'(NUM_COUNTERS))
								dec_status = ST_BUSY;
							else do_start = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin
		start_we    = 1'b0;
		start_wdata = item_q.now;
		acc_we      = 1'b0;
		acc_waddr   = cid;
		acc_wdata   = '0;
		stack_we    = 1'b0;
		if (state_q == S_DECODE) begin
			if (do_reg) begin
				start_we    = 1'b1;
				start_wdata = '0;
				acc_we      = 1'b1;
			end
			if (do_start) begin
				start_we  = 1'b1;
				acc_we    = 1'b1;
				acc_wdata = ACC_W'(ov_nz);
				stack_we  = 1'b1;
			end
		end else if (state_q == S_WALK && v_s2) begin
			acc_we    = 1'b1;
			acc_waddr = c_s2;
			acc_wdata = sat_sum[ACC_W] ? '1 : sat_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start_we) start_mem[cid] <= start_wdata;
		if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
		if (stack_we) stack_mem[depth_q[CW-1:0]] <= cid;
		stack_rd_q <= stack_mem[stack_raddr];
		start_rd_q <= start_mem[stack_rd_q];
		acc_rd_q   <= acc_mem[stack_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			reg_flags_q <= '0;
			act_flags_q <= '0;
			depth_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			issue_q     <= '0;
			walk_n_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					v_s1     <= 1'b0;
					v_s2     <= 1'b0;
					issue_q  <= '0;
					walk_n_q <= depth_q;
					if (do_reg) reg_flags_q[cid] <= 1'b1;
					if (do_unreg) reg_flags_q[cid] <= 1'b0;
					if (do_start) begin
						act_flags_q[cid] <= 1'b1;
						depth_q          <= depth_q + DW'(1);
					end
					if (do_pop) state_q <= S_POPRD;
					else if (do_start && ov_nz && depth_q != '0) state_q <= S_WALK;
					else state_q <= S_DONE;
				end
				S_POPRD: begin
					state_q <= S_CNTRD;
				end
				S_CNTRD: begin
					act_flags_q[pop_id_q] <= 1'b0;
					depth_q               <= depth_m1;
					state_q               <= S_SUB;
				end
				S_SUB: begin
					walk_n_q <= depth_q;
					issue_q  <= '0;
					v_s1     <= 1'b0;
					v_s2     <= 1'b0;
					state_q  <= (ov_nz && depth_q != '0) ? S_WALK : S_DONE;
				end
				S_WALK: begin
					v_s1 <= walk_more;
					v_s2 <= v_s1;
					if (walk_more) issue_q <= issue_q + DW'(1);
					if (!walk_more && !v_s1 && !v_s2) state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		c_s2 <= stack_rd_q;
		if (state_q == S_IDLE && item_valid) item_q <= item;
		if (state_q == S_DECODE) begin
			status_q <= dec_status;
			mvalid_q <= 1'b0;
		end
		if (state_q == S_POPRD) pop_id_q <= stack_rd_q;
		if (state_q == S_CNTRD) begin
			diff_q   <= item_q.now - start_rd_q;
			acc_q    <= acc_rd_q;
			mvalid_q <= 1'b1;
		end
		if (state_q == S_SUB) cycles_q <= diff_q - TIME_W'(acc_q);
	end

	assign pop_id8    = ID_W'(pop_id_q);
	assign item_ready = state_q == S_IDLE;
	assign res_valid  = state_q == S_DONE;

	always_comb begin
		res.status           = status_q;
		res.measured_valid   = mvalid_q;
		res.stopped_id       = mvalid_q ? pop_id8[SID_W-1:0] : '0;
		res.measured_cycles  = mvalid_q ? cycles_q : '0;
		res.stopped_overhead = mvalid_q ? acc_q : '0;
	end

	`NCP_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DW'(NUM_COUNTERS), "stack depth beyond pool size")
	`NCP_ASSERT_IMP(a_active_count, state_q == S_IDLE, $countones(act_flags_q) == int'(depth_q), "active flags disagree with stack depth")
	`NCP_ASSERT_NEXT(a_accept_decode, item_valid && item_ready, state_q == S_DECODE, "accepted transaction not decoded")
	`NCP_ASSERT_IMP(a_measure_ok, res_valid && res.measured_valid, res.status == ST_OK, "measurement with error status")
	`NCP_ASSERT_IMP(a_walk_bound, state_q == S_WALK, issue_q <= walk_n_q, "overhead walk past stack depth")

endmodule

[rtl/nested_cycle_profiler.sv]
// Nested cycle profiler top level: a pool of NUM_COUNTERS nestable stopwatches
// driven by register, unregister, start and stop transactions, one result per
// transaction. Input transactions are taken one at a time: register, unregister
// and rejected operations are decoded and then give their result. A start is
// decoded and, when its overhead is nonzero and at least one counter is active
// below it, runs the overhead walk. A stop is decoded, reads the popped id, then
// its start cycle and overhead, and subtracts; when its overhead is nonzero and
// at least one counter is still active below it, it then runs the overhead walk,
// which goes up the active stack from its bottom entry through the stack and
// overhead memories one entry per cycle. A result register lets the next
// transaction be accepted while the previous result waits on the output.
module nested_cycle_profiler
	import ncp_pkg::*;
#(
	parameter int NUM_COUNTERS = NUM_COUNTERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], counter_id[9:2], overhead[25:10], now[89:26], zero[95:90]
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[2:0], measured_valid[3], stopped_id[7:4], measured_cycles[71:8],
	// stopped_overhead[103:72]
	output logic [103:0] m_axis_tdata
);

	item_t   item;
	result_t res;
	result_t out_q;
	logic    res_valid;
	logic    res_ready;
	logic    out_full_q;

	assign item.func       = s_axis_tdata[1:0];
	assign item.counter_id = s_axis_tdata[9:2];
	assign item.overhead   = s_axis_tdata[25:10];
	assign item.now        = s_axis_tdata[89:26];

	ncp_engine #(
		.NUM_COUNTERS(NUM_COUNTERS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(s_axis_tvalid),
		.item_ready(s_axis_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_full_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_full_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_axis_tvalid = out_full_q;
	assign m_axis_tdata  = {out_q.stopped_overhead, out_q.measured_cycles, out_q.stopped_id,
		out_q.measured_valid, out_q.status};

endmodule
